[hw/rtl/tbs_pkg.sv]
package tbs_pkg;

  localparam int unsigned MaxSide    = 64;
  localparam int unsigned MaxPairs   = 4096;
  localparam int unsigned RangeDepth = MaxSide * MaxSide + 1;
  localparam int unsigned PairW      = 44;
  localparam int unsigned PairAw     = $clog2(MaxPairs);
  localparam int unsigned RangeAw    = $clog2(RangeDepth);
  localparam int unsigned CntW       = 13;
  localparam int unsigned PtrW       = 14;
  localparam logic [6:0]  GridReset  = 7'd50;

  typedef enum logic [2:0] {
    FN_ADD    = 3'd0,
    FN_FINISH = 3'd1,
    FN_RDRNG  = 3'd2,
    FN_RDIDX  = 3'd3,
    FN_CLEAR  = 3'd4
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD,
    ST_RD,
    ST_RV,
    ST_SEG,
    ST_LDA,
    ST_LDB,
    ST_MRG,
    ST_FA,
    ST_FB,
    ST_RNGW,
    ST_RNG,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    STS_OK   = 2'd0,
    STS_OVF  = 2'd1,
    STS_ADDR = 2'd2
  } status_e;

  function automatic logic [6:0] clamp_side(logic [6:0] v);
    logic [6:0] r;
    if (v == 7'd0) begin
      r = 7'd1;
    end else if (v > 7'(MaxSide)) begin
      r = 7'(MaxSide);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

[hw/rtl/tbs_ram.sv]
module tbs_ram #(
  parameter int unsigned Width = 44,
  parameter int unsigned Depth = 4096,
  parameter int unsigned Aw    = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/splat_tile_binning_sort_top.sv]
// Tile binning and depth sort for splats.
// Input stream: one command per transfer, tuser selects add, finish, range
// read, sorted index read or clear. Every command returns one output transfer
// holding status, pair count and read value.
// Add: one covered tile inside the grid per cycle; an add
// that covers no tile goes straight to the result.
// Finish: bottom-up merge sort between two pair banks in ceil(log2(n))
// passes, then a range scan over all 4097 range entries. Both pair banks
// are read through one shared read address. Reads pass through the RD and RV
// states; clear and unused codes go straight to the result.
// One command is worked on at a time; the next is taken once the result is
// in the output register, which holds it while the receiver stalls.
// Reset clears counts, the overflow flag and the grid registers (50 x 50);
// pair and range memories are not cleared. The user must write configuration
// only while the block is idle; the block itself does not enforce this.
module splat_tile_binning_sort_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [6:0]  cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // splat_id, visible, box_col_lo, box_row_lo, box_col_hi, box_row_hi,
  // depth_code, read_addr, zero fill
  input  logic [71:0] s_axis_tdata_i,
  // func
  input  logic [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // status, pair_count, read_value, zero fill
  output logic [31:0] m_axis_tdata_o
);
  import tbs_pkg::*;

  state_e state_q, state_d;
  logic [6:0]  cols_q, rows_q;
  logic [12:0] grid_q;
  logic [CntW-1:0] total_q, total_d;
  logic ovf_q, ovf_d, bank_q, bank_d;
  logic m_valid_q, m_valid_d;
  logic [31:0] m_data_q, m_data_d;
  func_e func_q, func_d;
  logic [12:0] addr_q, addr_d;
  logic [15:0] id_q, id_d, depth_q, depth_d, value_q, value_d;
  logic bad_q, bad_d;
  logic [5:0] clo_q, clo_d, chi_q, chi_d, rhi_q, rhi_d, r_q, r_d, c_q, c_d;
  logic [11:0] base_q, base_d, tp_q, tp_d;
  logic [PtrW-1:0] w_q, w_d, lo_q, lo_d, mid_q, mid_d, hi_q, hi_d;
  logic [PtrW-1:0] a_q, a_d, b_q, b_d, k_q, k_d;
  logic [PairW-1:0] ha_q, ha_d, hb_q, hb_d;
  logic [RangeAw-1:0] t_q, t_d;
  logic [CntW-1:0] p_q, p_d;

  logic pw_en, pw_bank;
  logic [PairAw-1:0] pw_addr;
  logic [PairW-1:0] pw_data, rd0, rd1, rd_cur;
  logic [PtrW-1:0] rd_addr;
  logic rw_en;
  logic [CntW-1:0] rng_rdata;

  logic [5:0] in_clo, in_rlo, in_chi, in_rhi, cols_m1, rows_m1, chi_eff, rhi_eff;
  logic [PtrW-1:0] n_ext, lo_w, lo_2w, w2, a_inc, b_inc;
  logic a_ok, b_ok, pick_b;
  logic [12:0] row_mul;

  tbs_ram #(.Width(PairW), .Depth(MaxPairs)) u_bank0 (
    .clk_i, .we_i(pw_en && !pw_bank), .waddr_i(pw_addr), .wdata_i(pw_data),
    .raddr_i(rd_addr[PairAw-1:0]), .rdata_o(rd0)
  );
  tbs_ram #(.Width(PairW), .Depth(MaxPairs)) u_bank1 (
    .clk_i, .we_i(pw_en && pw_bank), .waddr_i(pw_addr), .wdata_i(pw_data),
    .raddr_i(rd_addr[PairAw-1:0]), .rdata_o(rd1)
  );
  tbs_ram #(.Width(CntW), .Depth(RangeDepth)) u_range (
    .clk_i, .we_i(rw_en), .waddr_i(t_q), .wdata_i(p_q),
    .raddr_i(addr_q[RangeAw-1:0]), .rdata_o(rng_rdata)
  );

  assign rd_cur = bank_q ? rd1 : rd0;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  assign in_clo  = s_axis_tdata_i[22:17];
  assign in_rlo  = s_axis_tdata_i[28:23];
  assign in_chi  = s_axis_tdata_i[34:29];
  assign in_rhi  = s_axis_tdata_i[40:35];
  assign cols_m1 = 6'(cols_q - 7'd1);
  assign rows_m1 = 6'(rows_q - 7'd1);
  assign chi_eff = (in_chi > cols_m1) ? cols_m1 : in_chi;
  assign rhi_eff = (in_rhi > rows_m1) ? rows_m1 : in_rhi;
  assign row_mul = 13'(in_rlo) * 13'(cols_q);

  assign n_ext = PtrW'(total_q);
  assign lo_w  = lo_q + w_q;
  assign lo_2w = lo_q + (w_q << 1);
  assign w2    = w_q << 1;
  assign a_inc = a_q + 1'b1;
  assign b_inc = b_q + 1'b1;
  assign a_ok  = a_q < mid_q;
  assign b_ok  = b_q < hi_q;
  assign pick_b = b_ok && (!a_ok || (hb_q < ha_q));

  always_comb begin
    state_d = state_q;
    total_d = total_q;
    ovf_d = ovf_q;
    bank_d = bank_q;
    m_valid_d = m_valid_q;
    m_data_d = m_data_q;
    func_d = func_q;
    addr_d = addr_q;
    id_d = id_q;
    depth_d = depth_q;
    value_d = value_q;
    bad_d = bad_q;
    clo_d = clo_q;
    chi_d = chi_q;
    rhi_d = rhi_q;
    r_d = r_q;
    c_d = c_q;
    base_d = base_q;
    tp_d = tp_q;
    w_d = w_q;
    lo_d = lo_q;
    mid_d = mid_q;
    hi_d = hi_q;
    a_d = a_q;
    b_d = b_q;
    k_d = k_q;
    ha_d = ha_q;
    hb_d = hb_q;
    t_d = t_q;
    p_d = p_q;
    pw_en = 1'b0;
    pw_bank = bank_q;
    pw_addr = base_q + 12'(c_q);
    pw_data = {base_q + 12'(c_q), depth_q, id_q};
    rd_addr = PtrW'(addr_q);
    rw_en = 1'b0;

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          func_d = func_e'(s_axis_tuser_i);
          id_d = s_axis_tdata_i[15:0];
          depth_d = s_axis_tdata_i[56:41];
          addr_d = s_axis_tdata_i[69:57];
          value_d = '0;
          bad_d = 1'b0;
          clo_d = in_clo;
          chi_d = chi_eff;
          rhi_d = rhi_eff;
          r_d = in_rlo;
          c_d = in_clo;
          base_d = row_mul[11:0];
          state_d = ST_DONE;
          case (s_axis_tuser_i)
            FN_ADD: begin
              if (s_axis_tdata_i[16] && in_rlo <= rhi_eff && in_clo <= chi_eff) begin
                state_d = ST_ADD;
              end
            end
            FN_FINISH: begin
              w_d = PtrW'(1);
              lo_d = '0;
              t_d = '0;
              p_d = '0;
              rd_addr = '0;
              state_d = (total_q > CntW'(1)) ? ST_SEG : ST_RNGW;
            end
            FN_RDRNG, FN_RDIDX: state_d = ST_RD;
            FN_CLEAR: begin
              total_d = '0;
              ovf_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_ADD: begin
        if (total_q >= CntW'(MaxPairs)) begin
          ovf_d = 1'b1;
        end else begin
          pw_en = 1'b1;
          pw_addr = total_q[PairAw-1:0];
          total_d = total_q + 1'b1;
        end
        if (c_q == chi_q) begin
          if (r_q == rhi_q) begin
            state_d = ST_DONE;
          end else begin
            r_d = r_q + 1'b1;
            c_d = clo_q;
            base_d = base_q + 12'(cols_q);
          end
        end else begin
          c_d = c_q + 1'b1;
        end
      end
      ST_RD: state_d = ST_RV;
      ST_RV: begin
        if (func_q == FN_RDRNG) begin
          if (addr_q <= grid_q) begin
            value_d = 16'(rng_rdata);
          end else begin
            bad_d = 1'b1;
          end
        end else begin
          if (addr_q < total_q) begin
            value_d = rd_cur[15:0];
          end else begin
            bad_d = 1'b1;
          end
        end
        state_d = ST_DONE;
      end
      ST_SEG: begin
        mid_d = (lo_w > n_ext) ? n_ext : lo_w;
        hi_d = (lo_2w > n_ext) ? n_ext : lo_2w;
        a_d = lo_q;
        b_d = (lo_w > n_ext) ? n_ext : lo_w;
        k_d = lo_q;
        rd_addr = lo_q;
        state_d = ST_LDA;
      end
      ST_LDA: begin
        ha_d = rd_cur;
        rd_addr = b_q;
        state_d = ST_LDB;
      end
      ST_LDB: begin
        hb_d = rd_cur;
        state_d = ST_MRG;
      end
      ST_MRG: begin
        if (!a_ok && !b_ok) begin
          if (lo_2w < n_ext) begin
            lo_d = lo_2w;
            state_d = ST_SEG;
          end else begin
            bank_d = !bank_q;
            lo_d = '0;
            w_d = w2;
            rd_addr = '0;
            state_d = (w2 < n_ext) ? ST_SEG : ST_RNGW;
          end
        end else begin
          pw_en = 1'b1;
          pw_bank = !bank_q;
          pw_addr = k_q[PairAw-1:0];
          pw_data = pick_b ? hb_q : ha_q;
          k_d = k_q + 1'b1;
          if (pick_b) begin
            b_d = b_inc;
            rd_addr = b_inc;
            state_d = ST_FB;
          end else begin
            a_d = a_inc;
            rd_addr = a_inc;
            state_d = ST_FA;
          end
        end
      end
      ST_FA: begin
        ha_d = rd_cur;
        state_d = ST_MRG;
      end
      ST_FB: begin
        hb_d = rd_cur;
        state_d = ST_MRG;
      end
      ST_RNGW: begin
        rd_addr = PtrW'(p_q);
        tp_d = rd_cur[43:32];
        state_d = ST_RNG;
      end
      ST_RNG: begin
        if (p_q < total_q && 13'(tp_q) < t_q) begin
          p_d = p_q + 1'b1;
          rd_addr = PtrW'(p_q) + 1'b1;
          state_d = ST_RNGW;
        end else begin
          rw_en = 1'b1;
          rd_addr = PtrW'(p_q);
          if (t_q == RangeAw'(RangeDepth - 1)) begin
            state_d = ST_DONE;
          end else begin
            t_d = t_q + 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d = {1'b0, value_q, total_q,
                      bad_q ? STS_ADDR : (ovf_q ? STS_OVF : STS_OK)};
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cols_q <= GridReset;
      rows_q <= GridReset;
      grid_q <= 13'(GridReset) * 13'(GridReset);
      total_q <= '0;
      ovf_q <= 1'b0;
      bank_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i && !cfg_idx_i) begin
        cols_q <= clamp_side(cfg_data_i);
      end
      if (cfg_we_i && cfg_idx_i) begin
        rows_q <= clamp_side(cfg_data_i);
      end
      grid_q <= 13'(cols_q) * 13'(rows_q);
      total_q <= total_d;
      ovf_q <= ovf_d;
      bank_q <= bank_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
    func_q <= func_d;
    addr_q <= addr_d;
    id_q <= id_d;
    depth_q <= depth_d;
    value_q <= value_d;
    bad_q <= bad_d;
    clo_q <= clo_d;
    chi_q <= chi_d;
    rhi_q <= rhi_d;
    r_q <= r_d;
    c_q <= c_d;
    base_q <= base_d;
    tp_q <= tp_d;
    w_q <= w_d;
    lo_q <= lo_d;
    mid_q <= mid_d;
    hi_q <= hi_d;
    a_q <= a_d;
    b_q <= b_d;
    k_q <= k_d;
    ha_q <= ha_d;
    hb_q <= hb_d;
    t_q <= t_d;
    p_q <= p_d;
  end

endmodule
